[rtl/core/oiset_pkg.sv]
// Shared types, opcodes and bit-search helpers for the ordered integer set.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
package oiset_pkg;

	// Default key width: universe is 0 .. 2^KEY_BITS - 1
	localparam int KEY_BITS_DEF = 12;

	// Operation codes carried by the func field
	typedef enum logic [2:0] {
		FN_INSERT      = 3'd0,
		FN_INSERT_PRED = 3'd1,
		FN_DELETE      = 3'd2,
		FN_PRED        = 3'd3,
		FN_SUCC        = 3'd4
	} func_t;

	// Datapath step selected by the controller each cycle
	typedef enum logic [3:0] {
		DP_NOP,
		DP_CLEAR,
		DP_LOAD,
		DP_START,
		DP_RMW,
		DP_UPD_INS,
		DP_UPD_DEL,
		DP_DSRCH,
		DP_LEAF1,
		DP_SUM,
		DP_LEAF2,
		DP_EMIT
	} dp_step_t;

	typedef struct packed {
		dp_step_t step;
		logic     le;         // search for largest at or below (else smallest at or above)
		logic     minus_one;  // search from key - 1 (strict predecessor)
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;  // last word of the clearing sweep
		logic settled;     // answer known from min/max alone
		logic hit;         // masked word holds a set bit
		logic none_end;    // search ran off the edge of the universe
		logic del_search;  // delete removed min or max, rescan needed
		logic out_free;    // result register can take a beat
	} dp_stat_t;

	// Bits 0 .. b set
	function automatic logic [63:0] mask_upto(input logic [5:0] b);
		return {64{1'b1}} >> (6'd63 - b);
	endfunction

	// Bits b .. 63 set
	function automatic logic [63:0] mask_from(input logic [5:0] b);
		return {64{1'b1}} << b;
	endfunction

	// Index of the highest set bit, zero when none
	function automatic logic [5:0] top_bit(input logic [63:0] v);
		logic [5:0] r;
		r = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) r = 6'(i);
		end
		return r;
	endfunction

	// Index of the lowest set bit, zero when none
	function automatic logic [5:0] bottom_bit(input logic [63:0] v);
		logic [5:0] r;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			if (v[i]) r = 6'(i);
		end
		return r;
	endfunction

endpackage

[rtl/core/oiset_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Holds the leaf and summary bitmaps of the ordered integer set.
// No dependencies.
module oiset_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/oiset_dp.sv]
// Datapath of the ordered integer set: leaf and summary bitmap RAMs, min/max
// registers, search registers and the result register.
// Depends on oiset_pkg and oiset_ram.
module oiset_dp import oiset_pkg::*; #(
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic [KEY_BITS-1:0] key,
	output logic [KEY_BITS-1:0] answer_key,
	output logic                found,
	output logic                res_valid,
	input  logic                res_stall
);

	localparam int LEAF_AW    = (KEY_BITS > 6) ? KEY_BITS - 6 : 1;
	localparam int LEAF_WORDS = (KEY_BITS > 6) ? (1 << (KEY_BITS - 6)) : 1;
	localparam int SUM_AW     = (LEAF_AW > 6) ? LEAF_AW - 6 : 1;
	localparam int SUM_WORDS  = (LEAF_AW > 6) ? (1 << (LEAF_AW - 6)) : 1;
	localparam int XB         = LEAF_AW + 6;
	localparam int SXB        = SUM_AW + 6;

	logic [KEY_BITS-1:0] key_q, min_q, max_q, ans_q, res_key_q, qx;
	logic                empty_q, ans_found_q, res_found_q, res_valid_q;
	logic                first_q, dir_q, tgt_q;
	logic [XB-1:0]       pos_q, qx_x, key_x, hit_x;
	logic [LEAF_AW-1:0]  pos_w, key_w, li_q, li, s_next, clr_q, leaf_raddr, leaf_waddr;
	logic [SXB-1:0]      s_x, key_wx, li_x;
	logic [SUM_AW-1:0]   sw_q, sw_nx, sum_raddr, sum_waddr;
	logic [5:0]          sb_q, pos_b, key_b, key_sb, pick;
	logic [63:0]         leaf_rd, sum_rd, leaf_wd, sum_wd, leaf_m, sum_m, enc_in, leaf_del;
	logic                leaf_we, sum_we;
	logic                leaf_end, sum_end, q_none, q_bound, del_min, del_max, hit, out_free;

	// Key and search-point decomposition into word index and bit index
	assign key_x  = XB'(key_q);
	assign key_w  = key_x[XB-1:6];
	assign key_b  = key_x[5:0];
	assign key_wx = SXB'(key_w);
	assign key_sb = key_wx[5:0];
	assign pos_w  = pos_q[XB-1:6];
	assign pos_b  = pos_q[5:0];
	assign qx     = cmd.minus_one ? key_q - KEY_BITS'(1) : key_q;
	assign qx_x   = XB'(qx);

	// Mask the word just read and pick the first set bit in search direction
	assign leaf_m = leaf_rd & (dir_q ? mask_upto(pos_b) : mask_from(pos_b));
	assign sum_m  = sum_rd & (first_q ? (dir_q ? mask_upto(sb_q) : mask_from(sb_q))
		: {64{1'b1}});

	always_comb begin
		unique case (cmd.step)
			DP_LEAF1: enc_in = leaf_m;
			DP_SUM:   enc_in = sum_m;
			default:  enc_in = leaf_rd;
		endcase
	end

	assign pick  = dir_q ? top_bit(enc_in) : bottom_bit(enc_in);
	assign hit_x = (cmd.step == DP_LEAF2) ? {li_q, pick} : {pos_w, pick};
	assign li_x  = {sw_q, pick};
	assign li    = li_x[LEAF_AW-1:0];
	assign hit   = (cmd.step == DP_LEAF1) ? (leaf_m != '0) : (sum_m != '0);

	// Neighbor word and summary word, and the edges of the universe
	assign leaf_end = dir_q ? (pos_w == '0) : (pos_w == LEAF_AW'(LEAF_WORDS - 1));
	assign s_next   = dir_q ? pos_w - LEAF_AW'(1) : pos_w + LEAF_AW'(1);
	assign s_x      = SXB'(s_next);
	assign sum_end  = dir_q ? (sw_q == '0) : (sw_q == SUM_AW'(SUM_WORDS - 1));
	assign sw_nx    = dir_q ? sw_q - SUM_AW'(1) : sw_q + SUM_AW'(1);

	// Settle the query from min/max where possible
	always_comb begin
		if (cmd.le) begin
			q_none  = (cmd.minus_one && key_q == '0) || empty_q || (qx < min_q);
			q_bound = (qx >= max_q);
		end else begin
			q_none  = empty_q || (qx > max_q);
			q_bound = (qx <= min_q);
		end
	end

	// Delete cases that move min or max
	assign leaf_del = leaf_rd & ~(64'd1 << key_b);
	assign del_min  = !empty_q && (key_q == min_q);
	assign del_max  = !empty_q && (key_q == max_q);
	assign out_free = !res_valid_q || !res_stall;

	// RAM address and write selection
	always_comb begin
		leaf_we    = 1'b0;
		sum_we     = 1'b0;
		leaf_waddr = key_w;
		sum_waddr  = key_wx[SXB-1:6];
		leaf_wd    = leaf_rd | (64'd1 << key_b);
		sum_wd     = sum_rd | (64'd1 << key_sb);
		leaf_raddr = key_w;
		sum_raddr  = key_wx[SXB-1:6];
		unique case (cmd.step)
			DP_CLEAR: begin
				leaf_we    = 1'b1;
				sum_we     = (clr_q < LEAF_AW'(SUM_WORDS));
				leaf_waddr = clr_q;
				sum_waddr  = clr_q[SUM_AW-1:0];
				leaf_wd    = '0;
				sum_wd     = '0;
			end
			DP_START: leaf_raddr = qx_x[XB-1:6];
			DP_UPD_INS: begin
				leaf_we = 1'b1;
				sum_we  = 1'b1;
			end
			DP_UPD_DEL: begin
				leaf_we = 1'b1;
				sum_we  = 1'b1;
				leaf_wd = leaf_del;
				sum_wd  = (leaf_del == '0) ? (sum_rd & ~(64'd1 << key_sb)) : sum_rd;
			end
			DP_DSRCH: leaf_raddr = pos_w;
			DP_LEAF1: sum_raddr = s_x[SXB-1:6];
			DP_SUM: begin
				leaf_raddr = li;
				sum_raddr  = sw_nx;
			end
			default: ;
		endcase
	end

	oiset_ram #(.WIDTH(64), .DEPTH(LEAF_WORDS), .AW(LEAF_AW)) u_leaf_ram (
		.clk   (clk),
		.we    (leaf_we),
		.waddr (leaf_waddr),
		.wdata (leaf_wd),
		.raddr (leaf_raddr),
		.rdata (leaf_rd)
	);

	oiset_ram #(.WIDTH(64), .DEPTH(SUM_WORDS), .AW(SUM_AW)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wd),
		.raddr (sum_raddr),
		.rdata (sum_rd)
	);

	// Control state: sweep counter, empty flag, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			empty_q     <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.step == DP_CLEAR) clr_q <= clr_q + LEAF_AW'(1);
			if (cmd.step == DP_UPD_INS) empty_q <= 1'b0;
			if (cmd.step == DP_UPD_DEL && del_min && del_max) empty_q <= 1'b1;
			if (cmd.step == DP_EMIT && out_free) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	// Payload: key, search registers, min/max, answer and result beat
	always_ff @(posedge clk) begin
		unique case (cmd.step)
			DP_LOAD: begin
				key_q       <= key;
				ans_q       <= '0;
				ans_found_q <= 1'b0;
			end
			DP_START: begin
				pos_q <= qx_x;
				dir_q <= cmd.le;
				tgt_q <= 1'b0;
				if (!q_none && q_bound) begin
					ans_q       <= cmd.le ? max_q : min_q;
					ans_found_q <= 1'b1;
				end
			end
			DP_UPD_INS: begin
				if (empty_q || key_q < min_q) min_q <= key_q;
				if (empty_q || key_q > max_q) max_q <= key_q;
			end
			DP_UPD_DEL: begin
				pos_q <= key_x;
				dir_q <= del_max;
				tgt_q <= 1'b1;
			end
			DP_LEAF1, DP_LEAF2: begin
				// Store the member found, into the answer or into min/max
				if (cmd.step == DP_LEAF2 || hit) begin
					if (!tgt_q) begin
						ans_q       <= hit_x[KEY_BITS-1:0];
						ans_found_q <= 1'b1;
					end else if (dir_q) begin
						max_q <= hit_x[KEY_BITS-1:0];
					end else begin
						min_q <= hit_x[KEY_BITS-1:0];
					end
				end else if (cmd.step == DP_LEAF1 && !leaf_end) begin
					sw_q    <= s_x[SXB-1:6];
					sb_q    <= s_x[5:0];
					first_q <= 1'b1;
				end
			end
			DP_SUM: begin
				if (hit) begin
					li_q <= li;
				end else if (!sum_end) begin
					sw_q    <= sw_nx;
					first_q <= 1'b0;
				end
			end
			DP_EMIT: begin
				if (out_free) begin
					res_key_q   <= ans_q;
					res_found_q <= ans_found_q;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.clear_last = (clr_q == LEAF_AW'(LEAF_WORDS - 1));
		stat.settled    = q_none || q_bound;
		stat.hit        = hit;
		stat.none_end   = (cmd.step == DP_LEAF1) ? leaf_end : sum_end;
		stat.del_search = (cmd.step == DP_UPD_DEL) && (del_min ^ del_max);
		stat.out_free   = out_free;
	end

	assign answer_key = res_key_q;
	assign found      = res_found_q;
	assign res_valid  = res_valid_q;

endmodule

[rtl/core/oiset_ctrl.sv]
// Controller of the ordered integer set: sequences clearing, searches and
// bitmap updates by issuing one datapath step per cycle.
// Depends on oiset_pkg.
module oiset_ctrl import oiset_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     op_valid,
	input  logic [2:0] func,
	output logic     op_stall,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_RMW,
		S_UPD,
		S_DSRCH,
		S_LEAF1,
		S_SUM,
		S_LEAF2,
		S_DONE
	} state_t;

	state_t state_q, after_search;
	func_t  kind_q;
	logic   stall_q, accept;

	assign accept       = op_valid && !stall_q;
	assign after_search = (kind_q == FN_INSERT_PRED) ? S_RMW : S_DONE;
	assign op_stall     = stall_q;

	// Decode the datapath step from the state
	always_comb begin
		cmd.le        = (kind_q != FN_SUCC);
		cmd.minus_one = (kind_q == FN_INSERT_PRED);
		unique case (state_q)
			S_CLEAR: cmd.step = DP_CLEAR;
			S_IDLE:  cmd.step = accept ? DP_LOAD : DP_NOP;
			S_START: cmd.step = DP_START;
			S_RMW:   cmd.step = DP_RMW;
			S_UPD:   cmd.step = (kind_q == FN_DELETE) ? DP_UPD_DEL : DP_UPD_INS;
			S_DSRCH: cmd.step = DP_DSRCH;
			S_LEAF1: cmd.step = DP_LEAF1;
			S_SUM:   cmd.step = DP_SUM;
			S_LEAF2: cmd.step = DP_LEAF2;
			S_DONE:  cmd.step = DP_EMIT;
			default: cmd.step = DP_NOP;
		endcase
	end

	// Hold state, operation kind and the input stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			kind_q  <= FN_INSERT;
			stall_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (stat.clear_last) begin
						state_q <= S_IDLE;
						stall_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (accept) begin
						kind_q  <= func_t'(func);
						stall_q <= 1'b1;
						unique case (func)
							FN_INSERT, FN_DELETE:            state_q <= S_RMW;
							FN_INSERT_PRED, FN_PRED, FN_SUCC: state_q <= S_START;
							default:                          state_q <= S_DONE;
						endcase
					end
				end
				S_START: state_q <= stat.settled ? after_search : S_LEAF1;
				S_RMW:   state_q <= S_UPD;
				S_UPD:   state_q <= stat.del_search ? S_DSRCH : S_DONE;
				S_DSRCH: state_q <= S_LEAF1;
				S_LEAF1: state_q <= (stat.hit || stat.none_end) ? after_search : S_SUM;
				S_SUM: begin
					if (stat.hit) state_q <= S_LEAF2;
					else if (stat.none_end) state_q <= after_search;
				end
				S_LEAF2: state_q <= after_search;
				S_DONE: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/ordered_integer_set_top.sv]
// Ordered integer set over keys 0 .. 2^KEY_BITS - 1, kept as a two-level bitmap
// (64-bit leaf words plus a summary of non-empty words) with min/max registers.
// Each accepted beat applies one operation (insert, insert returning strict
// predecessor, delete, predecessor at or below, successor at or above) and gives
// one result beat. After reset the block clears its bitmap RAMs, one leaf word
// per cycle, with op_stall high. It then takes one operation at a time: a spare
// code goes straight to its result; a predecessor or successor settled by
// min/max needs no bitmap search; insert and delete read, modify and write the
// leaf and summary words; an insert returning predecessor first searches, then
// does the same update. A bitmap search, and the rescan after deleting the min
// or max, is paced by the chain of dependent reads of the single-read-port leaf
// and summary RAMs (leaf word, summary word, leaf word). With KEY_BITS above 12
// a search also scans the empty summary words one by one. A finished result
// waits in the output register while the next beat enters; a stalled result
// holds the following operation in its last cycle.
// Depends on oiset_pkg, oiset_ctrl, oiset_dp.
module ordered_integer_set_top import oiset_pkg::*; #(
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	output logic                op_stall,
	input  logic [2:0]          func,
	input  logic [KEY_BITS-1:0] key,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [KEY_BITS-1:0] answer_key,
	output logic                found
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	oiset_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.func     (func),
		.op_stall (op_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	oiset_dp #(.KEY_BITS(KEY_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.key        (key),
		.answer_key (answer_key),
		.found      (found),
		.res_valid  (res_valid),
		.res_stall  (res_stall)
	);

endmodule

[rtl/core/oiset_checker.sv]
// Port-level checks for the ordered integer set, bound to the top level.
// Depends on oiset_pkg and ordered_integer_set_top.
module oiset_checker import oiset_pkg::*; #(
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                op_valid,
	input logic                op_stall,
	input logic [2:0]          func,
	input logic [KEY_BITS-1:0] key,
	input logic                res_valid,
	input logic                res_stall,
	input logic [KEY_BITS-1:0] answer_key,
	input logic                found
);

	// Hold a stalled result beat
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(answer_key) && $stable(found))
		else $error("stalled result beat changed");

	// Drive a zero key when nothing was found
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !found |-> answer_key == '0)
		else $error("answer_key not zero without found");

	// Stall the input after each accepted beat
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && !op_stall |=> op_stall)
		else $error("input accepted while busy");

	// Raise a result only at the end of a busy period
	a_res_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(op_stall))
		else $error("result appeared without an operation");

endmodule

bind ordered_integer_set_top oiset_checker #(.KEY_BITS(KEY_BITS)) u_oiset_checker (.*);

[tb/ordered_integer_set_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the ordered integer set: watches the op and result channels,
// predicts every result beat from a flat membership bitmap, compares field by field.
// Depends on oiset_pkg.
module ordered_integer_set_checker import oiset_pkg::*; #(
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	input  logic                op_stall,
	input  logic [2:0]          func,
	input  logic [KEY_BITS-1:0] key,
	input  logic                res_valid,
	input  logic                res_stall,
	input  logic [KEY_BITS-1:0] answer_key,
	input  logic                found,
	output int                  fail_count,
	output int                  pending
);
	localparam int UNIVERSE   = 1 << KEY_BITS;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [KEY_BITS-1:0] answer_key;
		logic                found;
	} neighbor_t;

	logic [UNIVERSE-1:0] member_bits;
	neighbor_t           due_answers[$];
	neighbor_t           oldest;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// Largest member at or below 'from'; none when 'from' is negative
	function automatic neighbor_t floor_member(input int from);
		neighbor_t hit;
		hit = '0;
		for (int i = from; i >= 0; i--) begin
			if (member_bits[i]) begin
				hit.answer_key = KEY_BITS'(i);
				hit.found      = 1'b1;
				return hit;
			end
		end
		return hit;
	endfunction

	// Smallest member at or above 'from'
	function automatic neighbor_t ceil_member(input int from);
		neighbor_t hit;
		hit = '0;
		for (int i = from; i < UNIVERSE; i++) begin
			if (member_bits[i]) begin
				hit.answer_key = KEY_BITS'(i);
				hit.found      = 1'b1;
				return hit;
			end
		end
		return hit;
	endfunction

	// Apply one operation to the set and return the answer it produces
	function automatic neighbor_t apply_op(input logic [2:0] code,
			input logic [KEY_BITS-1:0] k);
		neighbor_t ans;
		ans = '0;
		case (code)
			FN_INSERT: begin
				member_bits[k] = 1'b1;
			end
			FN_INSERT_PRED: begin
				// strict predecessor is taken before the key goes in
				ans = floor_member(int'(k) - 1);
				member_bits[k] = 1'b1;
			end
			FN_DELETE: begin
				member_bits[k] = 1'b0;
			end
			FN_PRED: begin
				ans = floor_member(int'(k));
			end
			FN_SUCC: begin
				ans = ceil_member(int'(k));
			end
			default: begin
				// spare codes leave the set alone and answer nothing
			end
		endcase
		return ans;
	endfunction

	function automatic void note_failure(input string what);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("%0t mismatch: %s", $realtime, what);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			member_bits = '0;
			due_answers.delete();
		end else begin
			// compare a result beat with the oldest prediction
			if (res_valid && !res_stall) begin
				if (due_answers.size() == 0) begin
					note_failure($sformatf("result beat with none due: answer_key=%0d found=%0b",
						answer_key, found));
				end else begin
					oldest = due_answers.pop_front();
					if (answer_key !== oldest.answer_key)
						note_failure($sformatf("answer_key expected %0d got %0d",
							oldest.answer_key, answer_key));
					if (found !== oldest.found)
						note_failure($sformatf("found expected %0b got %0b",
							oldest.found, found));
				end
			end
			// predict the result of an accepted op beat
			if (op_valid && !op_stall)
				due_answers.push_back(apply_op(func, key));
		end
		pending = due_answers.size();
	end

endmodule

[tb/tb_ordered_integer_set_top.sv]
`timescale 1ns / 100ps
// Stimulus and verdict for ordered_integer_set_top: directed set operations,
// then staged random traffic with random gaps and stalls on both channels.
// Depends on oiset_pkg, ordered_integer_set_top, ordered_integer_set_checker.
module tb_ordered_integer_set_top;
	import oiset_pkg::*;

	localparam int KEY_BITS     = KEY_BITS_DEF;
	localparam int UNIVERSE     = 1 << KEY_BITS;
	localparam int KEY_MAX      = UNIVERSE - 1;
	localparam int KEY_MID      = UNIVERSE / 2;
	localparam int RANDOM_ITEMS = 950;
	localparam int STAGE_LEN    = 240;
	localparam int IDLE_PCT     = 21;
	// Worst correct gap: the clearing sweep, or a search behind a run of receiver
	// stalls; taken many times over.
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
	localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                op_valid  = 1'b0;
	logic                op_stall;
	logic [2:0]          func      = FN_INSERT;
	logic [KEY_BITS-1:0] key       = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	logic [KEY_BITS-1:0] answer_key;
	logic                found;

	int   fail_count;
	int   pending;
	int   quiet_cycles = 0;
	logic calm = 1'b0;

	// Operation mix per random stage: sparse, dense window, emptying, mixed.
	// Whatever is left of 100 goes to the spare codes.
	int         func_weight [0:3][0:4] = '{
		'{15, 15, 10, 28, 28},
		'{30, 15, 20, 15, 15},
		'{ 5,  5, 55, 17, 17},
		'{25, 15, 22, 17, 17}
	};
	logic [2:0] op_codes [0:4] = '{FN_INSERT, FN_INSERT_PRED, FN_DELETE, FN_PRED, FN_SUCC};

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	ordered_integer_set_top #(.KEY_BITS(KEY_BITS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_stall  (op_stall),
		.func      (func),
		.key       (key),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.answer_key(answer_key),
		.found     (found)
	);

	ordered_integer_set_checker #(.KEY_BITS(KEY_BITS)) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_stall  (op_stall),
		.func      (func),
		.key       (key),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.answer_key(answer_key),
		.found     (found),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// Stall result beats at random, except during the calm stretch
	always @(negedge clk)
		res_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if ((op_valid && !op_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one op beat after an optional random gap; return at the next
	// falling edge once it is accepted
	task automatic send_beat(input logic [2:0] code, input logic [KEY_BITS-1:0] k);
		while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
			op_valid <= 1'b0;
			@(negedge clk);
		end
		op_valid <= 1'b1;
		func     <= code;
		key      <= k;
		do @(posedge clk); while (op_stall);
		@(negedge clk);
	endtask

	// Hold the op channel idle until every predicted result has come back
	task automatic hold_until_drained();
		op_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic logic [2:0] pick_func(input int stage);
		int roll;
		roll = $urandom_range(99);
		for (int i = 0; i < 5; i++) begin
			if (roll < func_weight[stage][i])
				return op_codes[i];
			roll -= func_weight[stage][i];
		end
		return 3'($urandom_range(FUNC_SPARE_LAST, FUNC_SPARE_FIRST));
	endfunction

	// Mix universe extremes, leaf-word edges, the stage window and the full range
	function automatic logic [KEY_BITS-1:0] pick_key(input int lo, input int span);
		int roll;
		roll = $urandom_range(99);
		if (roll < 6)
			return roll[0] ? KEY_BITS'(KEY_MAX) : '0;
		if (roll < 14)
			return KEY_BITS'($urandom_range(UNIVERSE / 64 - 1) * 64 + (roll[0] ? 63 : 0));
		if (roll < 60)
			return KEY_BITS'(lo + $urandom_range(span - 1));
		return KEY_BITS'($urandom);
	endfunction

	initial begin
		logic [KEY_BITS-1:0] placed[$];
		logic [2:0]          code;
		logic [KEY_BITS-1:0] k;
		int                  stage;
		int                  win_lo;
		int                  win_span;
		int                  slot;

		stage    = 0;
		win_lo   = 0;
		win_span = UNIVERSE;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty set: no neighbors, absent delete, spare codes
		send_beat(FN_PRED, '0);
		send_beat(FN_SUCC, KEY_BITS'(KEY_MAX));
		send_beat(FN_DELETE, KEY_BITS'(100));
		send_beat(FUNC_SPARE_FIRST, KEY_BITS'(KEY_MAX));
		send_beat(FUNC_SPARE_LAST, '0);
		send_beat(FN_INSERT_PRED, '0);
		// build {0, 64, mid, max} and search across leaf words
		send_beat(FN_INSERT, KEY_BITS'(KEY_MAX));
		send_beat(FN_INSERT, KEY_BITS'(KEY_MID));
		send_beat(FN_INSERT, KEY_BITS'(64));
		send_beat(FN_PRED, KEY_BITS'(KEY_MAX));
		send_beat(FN_PRED, KEY_BITS'(KEY_MAX - 1));
		send_beat(FN_PRED, KEY_BITS'(KEY_MID - 1));
		send_beat(FN_PRED, KEY_BITS'(63));
		send_beat(FN_SUCC, '0);
		send_beat(FN_SUCC, KEY_BITS'(65));
		send_beat(FN_SUCC, KEY_BITS'(KEY_MID + 1));
		// present keys: set unchanged, strict predecessor still answered; then new key 1
		send_beat(FN_INSERT_PRED, KEY_BITS'(KEY_MAX));
		send_beat(FN_INSERT, KEY_BITS'(KEY_MID));
		send_beat(FN_INSERT_PRED, KEY_BITS'(1));
		// remove min and max, then empty the set
		send_beat(FN_DELETE, '0);
		send_beat(FN_DELETE, KEY_BITS'(KEY_MAX));
		send_beat(FN_SUCC, KEY_BITS'(KEY_MID + 1));
		send_beat(FN_PRED, '0);
		send_beat(FN_DELETE, KEY_BITS'(1));
		send_beat(FN_DELETE, KEY_BITS'(64));
		send_beat(FN_DELETE, KEY_BITS'(KEY_MID));
		send_beat(FN_SUCC, '0);
		hold_until_drained();

		// staged random traffic
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % STAGE_LEN == 0) begin
				stage    = n / STAGE_LEN;
				win_span = (stage == 0) ? UNIVERSE : (64 << stage);
				win_lo   = $urandom_range(UNIVERSE - win_span);
				if (stage == 2)
					hold_until_drained();
			end
			calm <= (n >= 300 && n < 420);
			code = pick_func(stage);
			k    = pick_key(win_lo, win_span);
			// aim most deletes at keys put in earlier
			if (code == FN_DELETE && placed.size() != 0 && $urandom_range(99) < 75) begin
				slot = $urandom_range(placed.size() - 1);
				k    = placed[slot];
				placed.delete(slot);
			end
			if (code == FN_INSERT || code == FN_INSERT_PRED)
				placed.push_back(k);
			send_beat(code, k);
		end

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
